// ===== sv/jls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types and constants for the JSON Lines line splitter.
// ----------------------------------------------------------------------------
package jls_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] sequence_number;
        logic [31:0] source_line_out;
        logic [31:0] raw_start;
        logic [31:0] raw_length;
        logic [31:0] json_start;
        logic [31:0] json_length;
    } rec_item_t;

    // Byte class as decided by the front end
    typedef struct packed {
        logic is_final;
        logic is_lf;
        logic is_cr;
        logic is_blank;
        logic is_bom0;
        logic is_bom1;
        logic is_bom2;
    } byte_class_t;

    localparam int CLS_W = $bits(byte_class_t);

endpackage

// ===== sv/jls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_front
// Accepts bytes, classifies them and tags each with its byte offset.
// ----------------------------------------------------------------------------
module jls_front #(
    parameter int OFFSET_BITS = jls_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  jls_pkg::byte_item_t                 byte_item,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [OFFSET_BITS+jls_pkg::CLS_W-1:0] q_wdata
);
    import jls_pkg::*;

    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    byte_class_t            cls;
    logic [7:0]             b;

    assign b          = byte_item.data_byte;
    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    always_comb
    begin
        cls.is_final = byte_item.is_final;
        cls.is_lf    = (b == CH_LF);
        cls.is_cr    = (b == CH_CR);
        cls.is_blank = (b == CH_SPACE) || ((b >= CH_HT) && (b <= CH_CR));
        cls.is_bom0  = (b == BOM_B0);
        cls.is_bom1  = (b == BOM_B1);
        cls.is_bom2  = (b == BOM_B2);
    end

    assign q_wdata = {offset_reg, cls};

    // Restart the offset after the final byte of the content
    always_comb
    begin
        offset_next = offset_reg;
        if (q_push)
        begin
            if (byte_item.is_final)
                offset_next = '0;
            else
                offset_next = offset_reg + OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end

endmodule

// ===== sv/jls_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_queue
// Short first-in first-out queue between the front end and the line tracker.
// ----------------------------------------------------------------------------
module jls_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = jls_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    import jls_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/jls_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_back
// Tracks line, text span and marker state; registers one record per line with text.
// ----------------------------------------------------------------------------
module jls_back #(
    parameter int OFFSET_BITS = jls_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_empty,
    input  logic [OFFSET_BITS+jls_pkg::CLS_W-1:0] q_rdata,
    output logic                                  q_pop,
    output logic                                  rec_valid,
    input  logic                                  rec_stall,
    output jls_pkg::rec_item_t                    rec_item
);
    import jls_pkg::*;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_EF    = 2'd1;
    localparam logic [1:0] PH_EFBB  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [OFFSET_BITS-1:0] line_begin_reg, line_begin_next;
    logic [OFFSET_BITS-1:0] first_reg, first_next;
    logic [OFFSET_BITS-1:0] end_reg, end_next;
    logic [31:0]            line_count_reg, line_count_next;
    logic [31:0]            emitted_reg, emitted_next;
    logic                   has_reg, has_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   prev_cr_reg, prev_cr_next;
    logic                   rec_valid_reg, rec_valid_next;
    rec_item_t              rec_item_reg, rec_item_next;

    byte_class_t            cls;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] first_t, end_t;
    logic                   has_t;
    logic [1:0]             phase_t;
    logic                   mark;
    logic                   emit;
    logic [OFFSET_BITS-1:0] raw_adj;
    logic [OFFSET_BITS-1:0] raw_len;
    logic [OFFSET_BITS-1:0] json_len;

    assign cls   = byte_class_t'(q_rdata[CLS_W-1:0]);
    assign pos   = q_rdata[CLS_W +: OFFSET_BITS];
    assign nxt   = pos + OFFSET_BITS'(1);
    assign q_pop = !q_empty && (!rec_valid_reg || !rec_stall);

    // Text span and marker tracking for a byte that is not a line feed
    always_comb
    begin
        has_t   = has_reg;
        first_t = first_reg;
        end_t   = end_reg;
        phase_t = phase_reg;
        mark    = 1'b0;
        if (!cls.is_lf)
        begin
            if (cls.is_blank)
            begin
                if (phase_reg == PH_EF || phase_reg == PH_EFBB)
                    phase_t = PH_DONE;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        phase_t = cls.is_bom0 ? PH_EF : PH_DONE;
                        mark    = 1'b1;
                    end
                    PH_EF:
                    begin
                        phase_t = cls.is_bom1 ? PH_EFBB : PH_DONE;
                        mark    = 1'b1;
                    end
                    PH_EFBB:
                    begin
                        phase_t = PH_DONE;
                        if (cls.is_bom2)
                            has_t = 1'b0;
                        else
                            mark = 1'b1;
                    end
                    default:
                    begin
                        mark = 1'b1;
                    end
                endcase
            end
            if (mark)
            begin
                if (!has_reg)
                begin
                    first_t = pos;
                    has_t   = 1'b1;
                end
                end_t = nxt;
            end
        end
    end

    // Line feed closes on its own offset and drops a preceding CR; a final
    // byte closes one past itself and drops itself if it is a CR.
    always_comb
    begin
        if (cls.is_lf)
            raw_adj = prev_cr_reg ? '1 : '0;
        else
            raw_adj = cls.is_cr ? '0 : OFFSET_BITS'(1);
    end

    assign raw_len  = pos - line_begin_reg + raw_adj;
    assign json_len = end_t - first_t;
    assign emit     = has_t && (cls.is_lf || cls.is_final);

    always_comb
    begin
        rec_item_next.sequence_number = emitted_reg;
        rec_item_next.source_line_out = line_count_reg;
        rec_item_next.raw_start       = 32'(line_begin_reg);
        rec_item_next.raw_length      = 32'(raw_len);
        rec_item_next.json_start      = 32'(first_t);
        rec_item_next.json_length     = 32'(json_len);
    end

    always_comb
    begin
        line_begin_next = line_begin_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        line_count_next = line_count_reg;
        emitted_next    = emitted_reg;
        has_next        = has_reg;
        phase_next      = phase_reg;
        prev_cr_next    = prev_cr_reg;
        rec_valid_next  = rec_valid_reg;
        if (q_pop)
        begin
            rec_valid_next = emit;
            if (cls.is_final)
            begin
                line_begin_next = '0;
                first_next      = '0;
                end_next        = '0;
                line_count_next = 32'd1;
                emitted_next    = '0;
                has_next        = 1'b0;
                phase_next      = PH_START;
                prev_cr_next    = 1'b0;
            end
            else
            begin
                prev_cr_next = cls.is_cr;
                emitted_next = emitted_reg + 32'(emit);
                if (cls.is_lf)
                begin
                    line_begin_next = nxt;
                    line_count_next = line_count_reg + 32'd1;
                    has_next        = 1'b0;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    has_next   = has_t;
                    first_next = first_t;
                    end_next   = end_t;
                    phase_next = phase_t;
                end
            end
        end
        else if (!rec_stall)
        begin
            rec_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_begin_reg <= '0;
            first_reg      <= '0;
            end_reg        <= '0;
            line_count_reg <= 32'd1;
            emitted_reg    <= '0;
            has_reg        <= 1'b0;
            phase_reg      <= PH_START;
            prev_cr_reg    <= 1'b0;
            rec_valid_reg  <= 1'b0;
        end
        else
        begin
            line_begin_reg <= line_begin_next;
            first_reg      <= first_next;
            end_reg        <= end_next;
            line_count_reg <= line_count_next;
            emitted_reg    <= emitted_next;
            has_reg        <= has_next;
            phase_reg      <= phase_next;
            prev_cr_reg    <= prev_cr_next;
            rec_valid_reg  <= rec_valid_next;
        end
    end

    // Load the record only when a line actually produces one
    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
            rec_item_reg <= rec_item_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec_item  = rec_item_reg;

endmodule

// ===== sv/jsonl_line_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsonl_line_splitter
// Splits a JSON Lines byte stream into per-line record descriptors.
// ----------------------------------------------------------------------------
// Feed the content one byte per item on the byte channel, with is_final set
// on its last byte; the block then returns to its reset state and the next
// byte starts new content. Each line that holds JSON text after trimming
// C-locale whitespace (and, on line 1 only, a leading EF BB BF marker) gives
// one record on the rec channel, issued when its line feed or the final byte
// is taken. The block takes one byte every clock cycle: the front end only
// classifies a byte and stamps its offset, and the line tracker behind a
// queue of QUEUE_DEPTH entries does a single add/subtract pass per byte, so
// one byte per cycle is sustained as long as records are taken. A record is
// registered when the byte that closes it leaves the queue. When rec_stall
// is held, the output register and then the queue fill, and byte_stall rises
// once QUEUE_DEPTH bytes are waiting. Offsets count modulo 2^OFFSET_BITS and
// are then cut or zero-extended to the 32-bit record fields.
// ----------------------------------------------------------------------------
module jsonl_line_splitter #(
    parameter int OFFSET_BITS = jls_pkg::OFFSET_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = jls_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  jls_pkg::byte_item_t byte_item,
    output logic                rec_valid,
    input  logic                rec_stall,
    output jls_pkg::rec_item_t  rec_item
);
    import jls_pkg::*;

    localparam int Q_W = OFFSET_BITS + CLS_W;

    // Queue entry: byte offset above the byte class
    logic [Q_W-1:0] q_wdata;
    logic [Q_W-1:0] q_rdata;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    // Classify each byte and stamp its offset
    jls_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // Decouple the front end from the record output stall
    jls_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // Track lines and text spans, drive the record register
    jls_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_item  (rec_item)
    );

endmodule

// ===== sv/jls_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_checker
// Port-level checks for the JSON Lines line splitter, bound to the top level.
// ----------------------------------------------------------------------------
module jls_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_stall,
    input jls_pkg::byte_item_t byte_item,
    input logic                rec_valid,
    input logic                rec_stall,
    input jls_pkg::rec_item_t  rec_item
);
    import jls_pkg::*;

    logic [31:0] last_seq_reg;
    logic        seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else if (rec_valid && !rec_stall)
        begin
            last_seq_reg <= rec_item.sequence_number;
            seen_reg     <= 1'b1;
        end
    end

    // Hold both sides quiet once reset has been seen at a clock edge
    a_reset_quiet: assert property (@(posedge clk)
        (!rst_n && $past(!rst_n)) |-> (!rec_valid && !byte_stall))
        else $error("record valid or byte stall during reset");

    // Advance sequence numbers by one, or restart at zero on new content
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && !rec_stall && seen_reg) |->
            (rec_item.sequence_number == last_seq_reg + 32'd1) ||
            (rec_item.sequence_number == 32'd0))
        else $error("record sequence number skipped or repeated");

    // Hold a stalled record
    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_stall) |=> (rec_valid && $stable(rec_item)))
        else $error("stalled record changed");

    // Hold a stalled byte
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_stall) |=> (byte_valid && $stable(byte_item)))
        else $error("stalled byte changed");

endmodule

bind jsonl_line_splitter jls_checker u_jls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec_item   (rec_item)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON Lines line splitter.
// ----------------------------------------------------------------------------
// A short table of hand-written content runs first, covering the marker on
// line 1, a broken marker, CR/LF endings and whitespace-only content. A few
// rows carry a record typed in by hand. Random JSON-like documents and raw
// noise follow. Every accepted byte goes through a line-tracking predictor,
// and every record taken from the block is compared field by field with the
// oldest expected record. The byte side sends in bursts with random gaps. The
// record side stalls on a pattern that changes from time to time.
// ----------------------------------------------------------------------------
module tb_top;
    import jls_pkg::*;

    localparam int OB = OFFSET_BITS_DEFAULT;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_REPORTS = 50;

    typedef logic [OB-1:0] ofs_t;
    typedef enum logic [1:0] {BOM_LOOK, BOM_GOT_EF, BOM_GOT_EFBB, BOM_DONE} bom_state_t;

    // One row of the directed content: the byte, and optionally a record
    // written out by hand in place of the predicted one.
    typedef struct {
        logic [7:0] data;
        logic       fin;
        bit         typed;
        rec_item_t  rec;
    } dir_row_t;

    localparam rec_item_t NO_REC = '0;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    byte_item_t byte_item;
    logic       rec_valid;
    logic       rec_stall;
    rec_item_t  rec_item;

    // Predictor state: one copy of the line tracker
    ofs_t       pos_q;
    ofs_t       line_start;
    ofs_t       text_first;
    ofs_t       text_end_q;
    logic [31:0] line_no;
    logic [31:0] rec_count;
    bit         text_seen;
    bit         cr_last;
    bom_state_t bom;

    rec_item_t  pending_recs[$];
    byte_item_t plan[$];
    int         error_count = 0;

    string field_names [6] = '{"sequence_number", "source_line_out", "raw_start",
                               "raw_length", "json_start", "json_length"};

    // Hand-written content. Each final byte closes the content and resets.
    dir_row_t dir_rows [25] = '{
        // "{}\n": plain record on line 1
        '{8'h7B, 1'b0, 1'b0, NO_REC},
        '{8'h7D, 1'b0, 1'b0, NO_REC},
        '{8'h0A, 1'b0, 1'b1, '{32'd0, 32'd1, 32'd0, 32'd2, 32'd0, 32'd2}},
        // " x\r\n": leading space trimmed, one CR dropped from the raw span
        '{8'h20, 1'b0, 1'b0, NO_REC},
        '{8'h78, 1'b0, 1'b0, NO_REC},
        '{8'h0D, 1'b0, 1'b0, NO_REC},
        '{8'h0A, 1'b0, 1'b1, '{32'd1, 32'd2, 32'd3, 32'd2, 32'd4, 32'd1}},
        // empty line 3 gives nothing
        '{8'h0A, 1'b0, 1'b0, NO_REC},
        // top byte value closes line 4 as the final byte
        '{8'hFF, 1'b1, 1'b1, '{32'd2, 32'd4, 32'd8, 32'd1, 32'd8, 32'd1}},
        // " EF BB BF [ \r" final on CR: marker removed after whitespace
        '{8'h20, 1'b0, 1'b0, NO_REC},
        '{8'hEF, 1'b0, 1'b0, NO_REC},
        '{8'hBB, 1'b0, 1'b0, NO_REC},
        '{8'hBF, 1'b0, 1'b0, NO_REC},
        '{8'h5B, 1'b0, 1'b0, NO_REC},
        '{8'h0D, 1'b1, 1'b1, '{32'd0, 32'd1, 32'd0, 32'd5, 32'd4, 32'd1}},
        // broken marker "EF A", final byte is a line feed
        '{8'hEF, 1'b0, 1'b0, NO_REC},
        '{8'h41, 1'b0, 1'b0, NO_REC},
        '{8'h0A, 1'b1, 1'b1, '{32'd0, 32'd1, 32'd0, 32'd2, 32'd0, 32'd2}},
        // marker alone: nothing left after removal
        '{8'hEF, 1'b0, 1'b0, NO_REC},
        '{8'hBB, 1'b0, 1'b0, NO_REC},
        '{8'hBF, 1'b1, 1'b0, NO_REC},
        // whitespace only
        '{8'h09, 1'b0, 1'b0, NO_REC},
        '{8'h0B, 1'b0, 1'b0, NO_REC},
        '{8'h0C, 1'b1, 1'b0, NO_REC},
        // bottom byte value, alone and final
        '{8'h00, 1'b1, 1'b1, '{32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd1}}
    };

    jsonl_line_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_item (byte_item),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_item  (rec_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit: several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("jsonl_line_splitter regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Line-tracking predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] to32(ofs_t v);
        return 32'(v);
    endfunction

    function automatic bit is_ws(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_HT && b <= CH_CR);
    endfunction

    task automatic reset_splitter();
        pos_q = '0;
        line_start = '0;
        line_no = 32'd1;
        rec_count = 32'd0;
        text_first = '0;
        text_end_q = '0;
        text_seen = 1'b0;
        bom = BOM_LOOK;
        cr_last = 1'b0;
    endtask

    task automatic mark_text(ofs_t at);
        if (!text_seen)
        begin
            text_first = at;
            text_seen = 1'b1;
        end
        text_end_q = at + ofs_t'(1);
    endtask

    // Close the current line; a record only if it holds json text
    task automatic close_record(input ofs_t end_ofs, input bit drop_cr,
                                output bit has_rec, output rec_item_t rec);
        has_rec = text_seen;
        rec = '0;
        if (text_seen)
        begin
            rec.sequence_number = rec_count;
            rec.source_line_out = line_no;
            rec.raw_start = to32(line_start);
            rec.raw_length = to32(end_ofs - line_start - ofs_t'(drop_cr));
            rec.json_start = to32(text_first);
            rec.json_length = to32(text_end_q - text_first);
            rec_count++;
        end
    endtask

    task automatic advance_splitter(input byte_item_t it, output bit has_rec,
                                    output rec_item_t rec);
        logic [7:0] b;
        ofs_t here;
        ofs_t nxt;
        b = it.data_byte;
        here = pos_q;
        nxt = pos_q + ofs_t'(1);
        has_rec = 1'b0;
        rec = '0;
        if (b == CH_LF)
        begin
            close_record(here, cr_last, has_rec, rec);
            line_start = nxt;
            line_no++;
            text_seen = 1'b0;
            bom = BOM_DONE;
        end
        else if (is_ws(b))
        begin
            // whitespace breaks a partial marker, but not the search for one
            if (bom == BOM_GOT_EF || bom == BOM_GOT_EFBB)
                bom = BOM_DONE;
        end
        else
        begin
            case (bom)
                BOM_LOOK:
                begin
                    bom = (b == BOM_B0) ? BOM_GOT_EF : BOM_DONE;
                    mark_text(here);
                end
                BOM_GOT_EF:
                begin
                    bom = (b == BOM_B1) ? BOM_GOT_EFBB : BOM_DONE;
                    mark_text(here);
                end
                BOM_GOT_EFBB:
                begin
                    bom = BOM_DONE;
                    // full marker: forget it and trim again
                    if (b == BOM_B2)
                        text_seen = 1'b0;
                    else
                        mark_text(here);
                end
                default:
                    mark_text(here);
            endcase
        end
        cr_last = (b == CH_CR);
        pos_q = nxt;
        if (it.is_final)
        begin
            if (b != CH_LF)
                close_record(nxt, b == CH_CR, has_rec, rec);
            reset_splitter();
        end
    endtask

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic byte_item_t mk_byte(logic [7:0] b);
        byte_item_t it;
        it.data_byte = b;
        it.is_final = 1'b0;
        return it;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 5))
            0: return CH_HT;
            1: return CH_VT;
            2: return CH_FF;
            3: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_text();
        logic [7:0] v;
        case ($urandom_range(0, 9))
            6:
            begin
                do v = 8'($urandom_range(0, 255)); while (v == CH_LF);
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0: v = BOM_B0;
                    1: v = BOM_B1;
                    default: v = BOM_B2;
                endcase
            end
            8: v = pick_ws();
            9: v = 8'($urandom_range(128, 255));
            default: v = 8'($urandom_range(33, 126));
        endcase
        return v;
    endfunction

    // Append one document: mostly well-formed lines, sometimes raw noise
    task automatic add_doc();
        byte_item_t doc[$];
        byte_item_t it;
        int n_lines;
        int ln;
        int body_len;
        int i;
        if ($urandom_range(0, 99) < 15)
        begin
            n_lines = $urandom_range(1, 20);
            for (i = 0; i < n_lines; i++)
            begin
                it = mk_byte(8'($urandom_range(0, 255)));
                it.is_final = ($urandom_range(0, 9) == 0);
                doc.push_back(it);
            end
        end
        else
        begin
            n_lines = $urandom_range(1, 6);
            for (ln = 0; ln < n_lines; ln++)
            begin
                repeat ($urandom_range(0, 3)) doc.push_back(mk_byte(pick_ws()));
                if (ln == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:
                        begin
                            doc.push_back(mk_byte(BOM_B0));
                            doc.push_back(mk_byte(BOM_B1));
                            doc.push_back(mk_byte(BOM_B2));
                        end
                        1: doc.push_back(mk_byte(BOM_B0));
                        2:
                        begin
                            doc.push_back(mk_byte(BOM_B0));
                            doc.push_back(mk_byte(BOM_B1));
                        end
                        3:
                        begin
                            doc.push_back(mk_byte(BOM_B0));
                            doc.push_back(mk_byte(BOM_B1));
                            doc.push_back(mk_byte(BOM_B2));
                            repeat ($urandom_range(1, 3)) doc.push_back(mk_byte(pick_ws()));
                        end
                        default: ;
                    endcase
                end
                body_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                repeat (body_len) doc.push_back(mk_byte(pick_text()));
                repeat ($urandom_range(0, 2)) doc.push_back(mk_byte(pick_ws()));
                if ($urandom_range(0, 1))
                    doc.push_back(mk_byte(CH_CR));
                doc.push_back(mk_byte(CH_LF));
            end
            // half the time the content ends without its last line feed
            if ($urandom_range(0, 1) && doc.size() > 1)
                void'(doc.pop_back());
        end
        it = doc.pop_back();
        it.is_final = 1'b1;
        doc.push_back(it);
        foreach (doc[i])
            plan.push_back(doc[i]);
    endtask

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------
    // Hold the item until taken, then predict what it causes.
    task automatic send_byte(input byte_item_t it, input bit typed, input rec_item_t typed_rec);
        bit got;
        rec_item_t r;
        byte_item <= it;
        byte_valid <= 1'b1;
        do @(posedge clk); while (byte_stall);
        advance_splitter(it, got, r);
        if (typed)
            pending_recs.push_back(typed_rec);
        else if (got)
            pending_recs.push_back(r);
    endtask

    task automatic idle_sender(int n);
        byte_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted record is out
    task automatic drain_pause();
        byte_valid <= 1'b0;
        do @(posedge clk); while (pending_recs.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Record side: stall pattern and checker
    // ------------------------------------------------------------------
    task automatic check_rec(input rec_item_t got);
        rec_item_t want;
        logic [0:5][31:0] w;
        logic [0:5][31:0] g;
        int k;
        if (pending_recs.size() == 0)
        begin
            if (error_count < MAX_REPORTS)
                $display("%0t: record with none expected: %h", $time, got);
            error_count++;
        end
        else
        begin
            want = pending_recs.pop_front();
            w = want;
            g = got;
            for (k = 0; k < 6; k++)
            begin
                if (w[k] != g[k])
                begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: %s expected %0d actual %0d",
                                 $time, field_names[k], w[k], g[k]);
                    error_count++;
                end
            end
        end
    endtask

    initial
    begin : rec_side
        int mode;
        int mode_left;
        int hold_left;
        logic nxt_stall;
        rec_stall = 1'b0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rec_valid && !rec_stall)
                check_rec(rec_item);
            // pick a new stall pattern now and then
            if (mode_left <= 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            nxt_stall = rec_stall;
            case (mode)
                0: nxt_stall = 1'b0;
                1: nxt_stall = ($urandom_range(0, 9) < 3);
                2: nxt_stall = ($urandom_range(0, 9) < 7);
                default:
                begin
                    // long stalls with short releases
                    if (hold_left > 0)
                        hold_left--;
                    else
                    begin
                        nxt_stall = ~rec_stall;
                        hold_left = nxt_stall ? $urandom_range(5, 20) : $urandom_range(1, 4);
                    end
                end
            endcase
            rec_stall <= nxt_stall;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int burst_left;
        int i;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        reset_splitter();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, sent back to back
        foreach (dir_rows[i])
            send_byte('{data_byte: dir_rows[i].data, is_final: dir_rows[i].fin},
                      dir_rows[i].typed, dir_rows[i].rec);
        drain_pause();

        while (plan.size() < RANDOM_ITEMS)
            add_doc();

        burst_left = 0;
        for (i = 0; i < plan.size(); i++)
        begin
            if (i != 0 && i % 500 == 0)
                drain_pause();
            else if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 8));
            end
            burst_left--;
            send_byte(plan[i], 1'b0, NO_REC);
        end

        // wait out the last records, then keep clocking to catch strays
        drain_pause();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("jsonl_line_splitter regression: pass");
        else
            $display("jsonl_line_splitter regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/jls_pkg.sv
sv/jls_front.sv
sv/jls_queue.sv
sv/jls_back.sv
sv/jsonl_line_splitter.sv
sv/jls_checker.sv
bench/tb_top.sv
